### design/eecb_pkg.sv
// Shared types and constants of the edge event counter bank.
package eecb_pkg;

	localparam int COUNTER_WIDTH_DEF = 32;
	localparam int NUM_COUNTERS_DEF  = 40;

	// Physical input lines fed by the three expanders.
	localparam int NUM_LINES   = 40;
	localparam int PORT_BITS   = 8;
	localparam int PREV_COUNT  = 5;
	localparam int IDX_W       = 6;
	localparam int VALUE_W     = 32;
	localparam int BAD_W       = 34;
	localparam int WD_W        = 16;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;

	localparam logic [WD_W-1:0] WD_RELOAD_RESET = 16'd60;
	localparam logic [WD_W-1:0] WD_STEP_RESET   = 16'd1;

	// Counters that make up the bad total.
	localparam int BAD_LINE_A = 7;
	localparam int BAD_LINE_B = 16;
	localparam int BAD_LINE_C = 17;
	localparam int BAD_LINE_D = 18;

	// Slots of the stored previous port bytes.
	localparam int PREV_MAIN_A = 0;
	localparam int PREV_MAIN_B = 1;
	localparam int PREV_AUX_A  = 2;
	localparam int PREV_AUX_B  = 3;
	localparam int PREV_EXT_A  = 4;

	// Register index taken from paddr[2].
	localparam logic REG_WD_RELOAD = 1'b0;
	localparam logic REG_WD_STEP   = 1'b1;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_READ   = 2'd1,
		OP_TICK   = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		EXP_MAIN = 2'd0,
		EXP_AUX  = 2'd1,
		EXP_EXT  = 2'd2
	} expander_t;

	typedef struct packed {
		logic                 changed;
		logic [NUM_LINES-1:0] inc;
	} sample_res_t;

	typedef struct packed {
		logic [WD_W-1:0] cooldown;
		logic            reset_request;
	} wd_status_t;

endpackage

### design/eecb_if.sv
// Request and response channel interfaces of the edge event counter bank.
interface eecb_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [1:0] expander;
	logic [7:0] port_a;
	logic [7:0] port_b;
	logic [5:0] counter_index;

	modport source (output valid, opcode, expander, port_a, port_b, counter_index,
		input ready);
	modport sink (input valid, opcode, expander, port_a, port_b, counter_index,
		output ready);
endinterface

interface eecb_rsp_if;
	logic        valid;
	logic        ready;
	logic        changed;
	logic [31:0] count_value;
	logic [33:0] bad_total;
	logic [15:0] cooldown_left;
	logic        reset_request;

	modport source (output valid, changed, count_value, bad_total, cooldown_left,
		reset_request, input ready);
	modport sink (input valid, changed, count_value, bad_total, cooldown_left,
		reset_request, output ready);
endinterface

### design/edge_event_counter_bank_core.sv
// Edge event counter bank: 40 rising-edge counters, watchdog and result register.
//
// The block takes one request per clock cycle while its output register is free.
// Sample requests compare the expander bytes with the stored ones and step the
// counter of each line that rose (lines 8, 10, 11 and 12 never; pair counters 9
// and 13 only with their latch armed), all lanes in the same cycle; reads and ticks
// take their counter values from the lanes. Each result appears in the output
// register in the cycle after its request transfer; req.ready stays high whenever
// that register is empty or is being drained. No clearing pass is needed after reset.
module edge_event_counter_bank_core #(
	parameter int COUNTER_WIDTH = eecb_pkg::COUNTER_WIDTH_DEF,
	parameter int NUM_COUNTERS  = eecb_pkg::NUM_COUNTERS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	eecb_req_if.sink                        req,
	eecb_rsp_if.source                      rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [eecb_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [eecb_pkg::APB_DATA_W-1:0] pwdata,
	output logic [eecb_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);
	import eecb_pkg::*;

	logic [WD_W-1:0] reload_q;
	logic [WD_W-1:0] step_q;
	logic            cfg_wr;
	logic            take;
	logic            out_valid_q;
	opcode_t         op;
	sample_res_t     smp;
	wd_status_t      wd_st;
	logic [VALUE_W-1:0] read_value;
	logic [BAD_W-1:0]   bad_sum;
	logic [NUM_COUNTERS-1:0][COUNTER_WIDTH-1:0] counts;

	logic               changed_q;
	logic [VALUE_W-1:0] value_q;
	logic [BAD_W-1:0]   bad_q;
	logic [WD_W-1:0]    cooldown_q;
	logic               flag_q;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= WD_RELOAD_RESET;
			step_q   <= WD_STEP_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_WD_RELOAD: reload_q <= pwdata[WD_W-1:0];
				REG_WD_STEP:   step_q   <= pwdata[WD_W-1:0];
				default:       reload_q <= reload_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WD_RELOAD: prdata = {{(APB_DATA_W-WD_W){1'b0}}, reload_q};
			REG_WD_STEP:   prdata = {{(APB_DATA_W-WD_W){1'b0}}, step_q};
			default:       prdata = '0;
		endcase
	end

	assign req.ready = !out_valid_q || rsp.ready;
	assign take      = req.valid && req.ready;
	assign op        = opcode_t'(req.opcode);

	eecb_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.enable   (take && (op == OP_SAMPLE)),
		.expander (req.expander),
		.port_a   (req.port_a),
		.port_b   (req.port_b),
		.res      (smp)
	);

	for (genvar i = 0; i < NUM_COUNTERS; i++) begin : g_lane
		logic lane_inc;
		if (i < NUM_LINES) begin : g_line
			assign lane_inc = smp.inc[i];
		end else begin : g_spare
			assign lane_inc = 1'b0;
		end
		eecb_lane #(
			.COUNTER_WIDTH (COUNTER_WIDTH)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.inc    (lane_inc),
			.count  (counts[i])
		);
	end

	eecb_merge #(
		.COUNTER_WIDTH (COUNTER_WIDTH),
		.NUM_COUNTERS  (NUM_COUNTERS)
	) u_merge (
		.counts     (counts),
		.index      (req.counter_index),
		.read_value (read_value),
		.bad_total  (bad_sum)
	);

	eecb_watchdog u_watchdog (
		.clk    (clk),
		.arst_n (arst_n),
		.reload (reload_q),
		.step   (step_q),
		.mark   (smp.changed),
		.tick   (take && (op == OP_TICK)),
		.status (wd_st)
	);

	// Output register; it loads on every request transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			changed_q  <= smp.changed;
			value_q    <= (op == OP_READ) ? read_value : '0;
			bad_q      <= (op == OP_TICK) ? bad_sum : '0;
			cooldown_q <= wd_st.cooldown;
			flag_q     <= wd_st.reset_request;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.changed       = changed_q;
	assign rsp.count_value   = value_q;
	assign rsp.bad_total     = bad_q;
	assign rsp.cooldown_left = cooldown_q;
	assign rsp.reset_request = flag_q;

	// The reset request never falls once raised.
	a_flag_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		wd_st.reset_request |=> wd_st.reset_request)
		else $error("watchdog reset request dropped");

	// Every request transfer leaves a result waiting in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> rsp.valid)
		else $error("accepted request produced no result");

	// The pair arming lines never step their own counters.
	a_arm_lines_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(counts[8] == '0) && (counts[12] == '0))
		else $error("pair arming line counted");

	// A pair counter steps only on an expander 0 sample that changed.
	a_pair_inc_gated: assert property (@(posedge clk) disable iff (!arst_n)
		(smp.inc[9] || smp.inc[13]) |-> (smp.changed && (req.expander == EXP_MAIN)))
		else $error("pair counter stepped outside a changed main sample");

endmodule

### design/eecb_decode.sv
// Rising edge detection on the sampled port bytes, with the pair latches.
module eecb_decode (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  enable,
	input  logic [1:0]            expander,
	input  logic [7:0]            port_a,
	input  logic [7:0]            port_b,
	output eecb_pkg::sample_res_t res
);
	import eecb_pkg::*;

	logic [PORT_BITS-1:0] prev_q [PREV_COUNT];
	logic [1:0]           armed_q;
	logic [1:0]           armed_n;
	logic [PORT_BITS-1:0] rise_a;
	logic [PORT_BITS-1:0] rise_b;
	logic [NUM_LINES-1:0] inc;
	logic                 hit;

	always_comb begin
		inc     = '0;
		hit     = 1'b0;
		armed_n = armed_q;
		rise_a  = '0;
		rise_b  = '0;
		case (expander_t'(expander))
			EXP_MAIN: begin
				hit    = (prev_q[PREV_MAIN_A] != port_a) || (prev_q[PREV_MAIN_B] != port_b);
				rise_a = ~prev_q[PREV_MAIN_A] & port_a;
				rise_b = ~prev_q[PREV_MAIN_B] & port_b;
				inc[7:0] = rise_a;
				// A latch armed in the same sample is added at once.
				inc[9]   = rise_b[1] & (armed_q[0] | rise_b[0]);
				inc[13]  = rise_b[5] & (armed_q[1] | rise_b[4]);
				inc[15:14] = rise_b[7:6];
				if (rise_b[1]) begin
					armed_n[0] = 1'b0;
				end else if (rise_b[0]) begin
					armed_n[0] = 1'b1;
				end
				if (rise_b[5]) begin
					armed_n[1] = 1'b0;
				end else if (rise_b[4]) begin
					armed_n[1] = 1'b1;
				end
			end
			EXP_AUX: begin
				hit    = (prev_q[PREV_AUX_A] != port_a) || (prev_q[PREV_AUX_B] != port_b);
				rise_a = ~prev_q[PREV_AUX_A] & port_a;
				rise_b = ~prev_q[PREV_AUX_B] & port_b;
				inc[23:16] = rise_a;
				inc[31:24] = rise_b;
			end
			EXP_EXT: begin
				hit    = prev_q[PREV_EXT_A] != port_a;
				rise_a = ~prev_q[PREV_EXT_A] & port_a;
				inc[39:32] = rise_a;
			end
			default: begin
				hit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PREV_COUNT; i++) begin
				prev_q[i] <= '0;
			end
			armed_q <= '0;
		end else if (enable && hit) begin
			case (expander_t'(expander))
				EXP_MAIN: begin
					prev_q[PREV_MAIN_A] <= port_a;
					prev_q[PREV_MAIN_B] <= port_b;
					armed_q             <= armed_n;
				end
				EXP_AUX: begin
					prev_q[PREV_AUX_A] <= port_a;
					prev_q[PREV_AUX_B] <= port_b;
				end
				EXP_EXT: begin
					prev_q[PREV_EXT_A] <= port_a;
				end
				default: begin
					armed_q <= armed_q;
				end
			endcase
		end
	end

	assign res.changed = enable & hit;
	assign res.inc     = enable ? inc : '0;

endmodule

### design/eecb_lane.sv
// One wrapping event counter lane.
module eecb_lane #(
	parameter int COUNTER_WIDTH = eecb_pkg::COUNTER_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     inc,
	output logic [COUNTER_WIDTH-1:0] count
);
	import eecb_pkg::*;

	logic [COUNTER_WIDTH-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (inc) begin
			count_q <= count_q + COUNTER_WIDTH'(1);
		end
	end

	assign count = count_q;

endmodule

### design/eecb_watchdog.sv
// Activity watchdog with cooldown and sticky reset request.
module eecb_watchdog (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [15:0]           reload,
	input  logic [15:0]           step,
	input  logic                  mark,
	input  logic                  tick,
	output eecb_pkg::wd_status_t  status
);
	import eecb_pkg::*;

	logic            act_q;
	logic            act_n;
	logic [WD_W-1:0] cd_q;
	logic [WD_W-1:0] cd_n;
	logic            flag_q;
	logic            flag_n;

	always_comb begin
		act_n  = act_q;
		cd_n   = cd_q;
		flag_n = flag_q;
		if (tick) begin
			if (act_q) begin
				cd_n  = reload;
				act_n = 1'b0;
			end else if (cd_q > step) begin
				cd_n = cd_q - step;
			end else begin
				cd_n = '0;
			end
			flag_n = flag_q | (cd_n == '0);
		end else if (mark) begin
			act_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			cd_q   <= WD_RELOAD_RESET;
			flag_q <= 1'b0;
		end else begin
			act_q  <= act_n;
			cd_q   <= cd_n;
			flag_q <= flag_n;
		end
	end

	// The result reports the state as it stands after the item.
	assign status.cooldown      = cd_n;
	assign status.reset_request = flag_n;

endmodule

### design/eecb_merge.sv
// Merges the lane counts into the read value and the bad total.
module eecb_merge #(
	parameter int COUNTER_WIDTH = eecb_pkg::COUNTER_WIDTH_DEF,
	parameter int NUM_COUNTERS  = eecb_pkg::NUM_COUNTERS_DEF
) (
	input  logic [NUM_COUNTERS-1:0][COUNTER_WIDTH-1:0] counts,
	input  logic [5:0]                                 index,
	output logic [31:0]                                read_value,
	output logic [33:0]                                bad_total
);
	import eecb_pkg::*;

	localparam int IW = $clog2(NUM_COUNTERS);

	logic [NUM_COUNTERS-1:0][VALUE_W-1:0] cnt32;
	logic [3:0][BAD_W-1:0]                bad_term;
	logic [BAD_LINE_D:0][BAD_W-1:0]       cnt34;
	logic                                 in_range;

	for (genvar i = 0; i < NUM_COUNTERS; i++) begin : g_ext
		if (COUNTER_WIDTH >= VALUE_W) begin : g_wide
			assign cnt32[i] = counts[i][VALUE_W-1:0];
		end else begin : g_narrow
			assign cnt32[i] = {{(VALUE_W-COUNTER_WIDTH){1'b0}}, counts[i]};
		end
	end

	for (genvar i = 0; i <= BAD_LINE_D; i++) begin : g_ext34
		if (COUNTER_WIDTH >= BAD_W) begin : g_wide
			assign cnt34[i] = counts[i][BAD_W-1:0];
		end else begin : g_narrow
			assign cnt34[i] = {{(BAD_W-COUNTER_WIDTH){1'b0}}, counts[i]};
		end
	end

	assign bad_term[0] = cnt34[BAD_LINE_A];
	assign bad_term[1] = cnt34[BAD_LINE_B];
	assign bad_term[2] = cnt34[BAD_LINE_C];
	assign bad_term[3] = cnt34[BAD_LINE_D];

	// Two-level adder tree; the sum wraps at 34 bits.
	assign bad_total = (bad_term[0] + bad_term[1]) + (bad_term[2] + bad_term[3]);

	assign in_range   = {1'b0, index} < 7'(NUM_COUNTERS);
	assign read_value = in_range ? cnt32[index[IW-1:0]] : '0;

endmodule
